// File: hdl/ppac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppac_pkg
// Shared types, constants and arithmetic helpers for the palette lookup and
// premultiplied alpha compositor.
// ----------------------------------------------------------------------------
package ppac_pkg;

  localparam int CHAN_W           = 8;
  localparam int PROD_W           = 2 * CHAN_W;
  localparam int RGB_W            = 3 * CHAN_W;
  localparam int PALETTE_ENTRIES  = 256;

  typedef enum logic [1:0] {
    OP_WR_COLOR    = 2'd0,
    OP_WR_COVERAGE = 2'd1,
    OP_PIXEL       = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  // Exact floor(p / 255) for any product of two 8-bit values.
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] sum;
    sum = {1'b0, p} + {{(CHAN_W + 1){1'b0}}, p[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
    return sum[PROD_W-1:CHAN_W];
  endfunction

endpackage

// File: hdl/ppac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppac_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module ppac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/palette_premultiplied_alpha_compose.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_premultiplied_alpha_compose
// Looks up a color and a coverage value per pixel in two loadable palettes and
// returns the color premultiplied by coverage, plus the coverage as alpha.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  --------+---------------------+---------------------------------------------
//  input   | in_valid / in_stall | op, table_entry, red_in, green_in, blue_in,
//          |                     | coverage_in, color_index, alpha_index
//  output  | out_valid/out_stall | out_red, out_green, out_blue, out_alpha
//
// One transaction is accepted per cycle while in_stall is low. A pixel then
// passes the palette read, the multiply and the divide by 255 into the
// output register. Table writes land in the palette memories at acceptance,
// so a pixel in the very next cycle already sees them.
// Reset clears only the stage valid bits; the palettes are undefined until
// written. Each stage moves whenever the stage after it is empty or moving, so
// bubbles close up and a stalled output still lets earlier stages fill.
// ----------------------------------------------------------------------------
module palette_premultiplied_alpha_compose #(
  parameter int PALETTE_ENTRIES = ppac_pkg::PALETTE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] table_entry,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [7:0] coverage_in,
  input  logic [7:0] color_index,
  input  logic [7:0] alpha_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int CW    = ppac_pkg::CHAN_W;
  localparam int PW    = ppac_pkg::PROD_W;
  localparam int RW    = ppac_pkg::RGB_W;
  localparam logic [CW:0] ENTRIES_LIM = (CW + 1)'(PALETTE_ENTRIES);

  // Handshake and stage control.
  logic accept;
  logic v1, v2, v3;
  logic ready1, ready2, ready3;

  assign ready3   = !v3 || !out_stall;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;
  assign accept   = in_valid && ready1;

  ppac_pkg::op_t op_code;
  assign op_code = ppac_pkg::op_t'(op);

  logic entry_ok, color_ok_in, alpha_ok_in;
  assign entry_ok    = {1'b0, table_entry} < ENTRIES_LIM;
  assign color_ok_in = {1'b0, color_index} < ENTRIES_LIM;
  assign alpha_ok_in = {1'b0, alpha_index} < ENTRIES_LIM;

  logic color_we, cov_we;
  assign color_we = accept && (op_code == ppac_pkg::OP_WR_COLOR) && entry_ok;
  assign cov_we   = accept && (op_code == ppac_pkg::OP_WR_COVERAGE) && entry_ok;

  // Stage 1: palette reads.
  logic [RW-1:0] rgb_rd;
  logic [CW-1:0] cov_rd;
  logic          color_ok, alpha_ok;

  ppac_ram #(.WIDTH(RW), .DEPTH(PALETTE_ENTRIES)) u_color_ram (
    .clk   (clk),
    .we    (color_we),
    .waddr (table_entry[IDX_W-1:0]),
    .wdata ({red_in, green_in, blue_in}),
    .re    (ready1),
    .raddr (color_index[IDX_W-1:0]),
    .rdata (rgb_rd)
  );

  ppac_ram #(.WIDTH(CW), .DEPTH(PALETTE_ENTRIES)) u_cov_ram (
    .clk   (clk),
    .we    (cov_we),
    .waddr (table_entry[IDX_W-1:0]),
    .wdata (coverage_in),
    .re    (ready1),
    .raddr (alpha_index[IDX_W-1:0]),
    .rdata (cov_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= accept && (op_code == ppac_pkg::OP_PIXEL);
    end
    if (ready1) begin
      color_ok <= color_ok_in;
      alpha_ok <= alpha_ok_in;
    end
  end

  // Stage 2: out-of-range entries read as zero, then the three products.
  logic [RW-1:0] rgb_eff;
  logic [CW-1:0] cov_eff;
  logic [PW-1:0] prod_r, prod_g, prod_b;
  logic [CW-1:0] alpha2;

  assign rgb_eff = color_ok ? rgb_rd : '0;
  assign cov_eff = alpha_ok ? cov_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
    if (ready2) begin
      prod_r <= PW'(rgb_eff[3*CW-1:2*CW]) * PW'(cov_eff);
      prod_g <= PW'(rgb_eff[2*CW-1:CW]) * PW'(cov_eff);
      prod_b <= PW'(rgb_eff[CW-1:0]) * PW'(cov_eff);
      alpha2 <= cov_eff;
    end
  end

  // Stage 3: divide by 255 into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
    if (ready3) begin
      out_red   <= ppac_pkg::div255(prod_r);
      out_green <= ppac_pkg::div255(prod_g);
      out_blue  <= ppac_pkg::div255(prod_b);
      out_alpha <= alpha2;
    end
  end

  assign out_valid = v3;

  // A table write or the unused op never creates a pipeline item.
  a_write_no_item: assert property (@(posedge clk) disable iff (rst)
    accept && (op_code != ppac_pkg::OP_PIXEL) |=> !v1)
    else $error("table write produced a pipeline item");

  // An accepted pixel always occupies stage 1 on the next cycle.
  a_pixel_enters: assert property (@(posedge clk) disable iff (rst)
    accept && (op_code == ppac_pkg::OP_PIXEL) |=> v1)
    else $error("accepted pixel was lost at stage 1");

  // A blocked multiply stage keeps its products.
  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !ready3 |=> v2 && $stable(prod_r) && $stable(prod_g) && $stable(prod_b))
    else $error("stage 2 changed while blocked");

  // Premultiplied channels can never exceed alpha.
  a_premult_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_red <= out_alpha) && (out_green <= out_alpha)
                  && (out_blue <= out_alpha))
    else $error("premultiplied channel exceeds alpha");

endmodule

// File: sim/tb_palette_premultiplied_alpha_compose.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_premultiplied_alpha_compose
// Loads the color palette and the coverage table, streams pixels through the
// compositor and checks every premultiplied result in order against a
// scoreboard that keeps its own copy of both tables. Both handshake sides
// idle at random, the receiver holds off long enough to back up the pipeline
// at least once, and pixels only ever read table entries already written.
// ----------------------------------------------------------------------------
module tb_palette_premultiplied_alpha_compose;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  class pixel_scoreboard;
    logic [23:0] color_mem [ppac_pkg::PALETTE_ENTRIES];
    logic [7:0]  cover_mem [ppac_pkg::PALETTE_ENTRIES];
    pixel_t      expected_pixels [$];
    int          fail_count = 0;

    function pixel_t premul_lookup(logic [7:0] ci, logic [7:0] ai);
      pixel_t      p;
      logic [23:0] rgb;
      int unsigned cov;
      rgb     = color_mem[ci];
      cov     = int'(cover_mem[ai]);
      p.red   = 8'((rgb[23:16] * cov) / 255);
      p.green = 8'((rgb[15:8] * cov) / 255);
      p.blue  = 8'((rgb[7:0] * cov) / 255);
      p.alpha = 8'(cov);
      return p;
    endfunction

    function void note_transaction(ppac_pkg::op_t kind, logic [7:0] entry, logic [7:0] r,
                                   logic [7:0] g, logic [7:0] b, logic [7:0] cov,
                                   logic [7:0] ci, logic [7:0] ai);
      case (kind)
        ppac_pkg::OP_WR_COLOR:    color_mem[entry] = {r, g, b};
        ppac_pkg::OP_WR_COVERAGE: cover_mem[entry] = cov;
        ppac_pkg::OP_PIXEL:       expected_pixels.push_back(premul_lookup(ci, ai));
        default: ;
      endcase
    endfunction

    task report(string what, int got, int want);
      $display("tb: mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
      fail_count++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report("unexpected pixel", int'(got), 0);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red) report("out_red", int'(got.red), int'(want.red));
      if (got.green !== want.green) report("out_green", int'(got.green), int'(want.green));
      if (got.blue !== want.blue) report("out_blue", int'(got.blue), int'(want.blue));
      if (got.alpha !== want.alpha) report("out_alpha", int'(got.alpha), int'(want.alpha));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] op;
  logic [7:0] table_entry;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] coverage_in;
  logic [7:0] color_index;
  logic [7:0] alpha_index;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  pixel_scoreboard sb = new;

  // Entries already written, so that pixels never read an undefined entry.
  bit         color_loaded [ppac_pkg::PALETTE_ENTRIES];
  bit         cover_loaded [ppac_pkg::PALETTE_ENTRIES];
  logic [7:0] color_loaded_list [$];
  logic [7:0] cover_loaded_list [$];

  bit hold_off_req = 1'b0;
  bit no_gaps = 1'b0;

  palette_premultiplied_alpha_compose u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .table_entry (table_entry),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .coverage_in (coverage_in),
    .color_index (color_index),
    .alpha_index (alpha_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_transaction(ppac_pkg::op_t'(op), table_entry, red_in, green_in, blue_in,
                          coverage_in, color_index, alpha_index);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_pixel(pixel_t'({out_red, out_green, out_blue, out_alpha}));
  end

  function automatic logic [7:0] rand8();
    return 8'($urandom);
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  task automatic send(ppac_pkg::op_t kind, logic [7:0] entry, logic [7:0] r, logic [7:0] g,
                      logic [7:0] b, logic [7:0] cov, logic [7:0] ci, logic [7:0] ai);
    if (kind == ppac_pkg::OP_WR_COLOR && !color_loaded[entry]) begin
      color_loaded[entry] = 1'b1;
      color_loaded_list.push_back(entry);
    end
    if (kind == ppac_pkg::OP_WR_COVERAGE && !cover_loaded[entry]) begin
      cover_loaded[entry] = 1'b1;
      cover_loaded_list.push_back(entry);
    end
    in_valid    <= 1'b1;
    op          <= kind;
    table_entry <= entry;
    red_in      <= r;
    green_in    <= g;
    blue_in     <= b;
    coverage_in <= cov;
    color_index <= ci;
    alpha_index <= ai;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_pixels.size() != 0);
  endtask

  task automatic send_random_item();
    int            r;
    ppac_pkg::op_t kind;
    logic [7:0]    ci;
    logic [7:0]    ai;
    r  = $urandom_range(0, 99);
    ci = rand8();
    ai = rand8();
    if (r < 20) kind = ppac_pkg::OP_WR_COLOR;
    else if (r < 35) kind = ppac_pkg::OP_WR_COVERAGE;
    else if (r < 96) kind = ppac_pkg::OP_PIXEL;
    else kind = ppac_pkg::OP_NONE;
    if (kind == ppac_pkg::OP_PIXEL) begin
      ci = color_loaded_list[$urandom_range(0, color_loaded_list.size() - 1)];
      ai = cover_loaded_list[$urandom_range(0, cover_loaded_list.size() - 1)];
    end
    send(kind, rand8(), rand8(), rand8(), rand8(), rand8(), ci, ai);
    sender_gap();
  endtask

  // Receiver: long runs without stalls, short stalls, now and then a long one.
  initial begin
    int r;
    int n;
    out_stall = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (64) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 20);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(10, 40);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_valid    = 1'b0;
    op          = ppac_pkg::OP_NONE;
    table_entry = '0;
    red_in      = '0;
    green_in    = '0;
    blue_in     = '0;
    coverage_in = '0;
    color_index = '0;
    alpha_index = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Extremes of both tables and of the scaling.
    send(ppac_pkg::OP_WR_COLOR, 8'd0, 8'd0, 8'd0, 8'd0, rand8(), rand8(), rand8());
    sender_gap();
    send(ppac_pkg::OP_WR_COLOR, 8'd255, 8'd255, 8'd255, 8'd255, rand8(), rand8(), rand8());
    sender_gap();
    send(ppac_pkg::OP_WR_COLOR, 8'hA5, 8'd255, 8'd0, 8'd128, rand8(), rand8(), rand8());
    sender_gap();
    send(ppac_pkg::OP_WR_COVERAGE, 8'd0, rand8(), rand8(), rand8(), 8'd0, rand8(), rand8());
    sender_gap();
    send(ppac_pkg::OP_WR_COVERAGE, 8'd255, rand8(), rand8(), rand8(), 8'd255, rand8(),
         rand8());
    sender_gap();
    send(ppac_pkg::OP_WR_COVERAGE, 8'h5A, rand8(), rand8(), rand8(), 8'd128, rand8(),
         rand8());
    sender_gap();
    send(ppac_pkg::OP_PIXEL, rand8(), rand8(), rand8(), rand8(), rand8(), 8'd255, 8'd255);
    send(ppac_pkg::OP_PIXEL, rand8(), rand8(), rand8(), rand8(), rand8(), 8'd255, 8'd0);
    send(ppac_pkg::OP_PIXEL, rand8(), rand8(), rand8(), rand8(), rand8(), 8'd0, 8'd255);
    send(ppac_pkg::OP_PIXEL, rand8(), rand8(), rand8(), rand8(), rand8(), 8'hA5, 8'h5A);
    send(ppac_pkg::OP_PIXEL, rand8(), rand8(), rand8(), rand8(), rand8(), 8'd255, 8'h5A);
    // The unused op must produce nothing.
    send(ppac_pkg::OP_NONE, rand8(), rand8(), rand8(), rand8(), rand8(), rand8(), rand8());
    // A pixel right behind a write of its entry must see the new value.
    send(ppac_pkg::OP_WR_COLOR, 8'd255, 8'd1, 8'd254, 8'd127, rand8(), rand8(), rand8());
    send(ppac_pkg::OP_PIXEL, rand8(), rand8(), rand8(), rand8(), rand8(), 8'd255, 8'd255);
    send(ppac_pkg::OP_WR_COVERAGE, 8'hA5, rand8(), rand8(), rand8(), 8'd1, rand8(), rand8());
    send(ppac_pkg::OP_PIXEL, rand8(), rand8(), rand8(), rand8(), rand8(), 8'hA5, 8'hA5);
    send(ppac_pkg::OP_PIXEL, rand8(), rand8(), rand8(), rand8(), rand8(), 8'hA5, 8'd255);
    wait_drained();

    for (int i = 0; i < 500; i++) begin
      // Back up the pipeline while transactions keep coming.
      if (i == 150) hold_off_req = 1'b1;
      no_gaps = (i >= 140 && i < 220) || (i >= 300 && i < 380);
      if (i == 250) wait_drained();
      send_random_item();
    end
    wait_drained();
    repeat (16) @(posedge clk);

    if (sb.fail_count == 0 && sb.expected_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
